FILE: sv/mbr_pkg.sv
// ----------------------------------------------------------------------------
// mbr_pkg: shared types and constants of the MSB-first bit reader
// Widths, request and status codes, and the command and result items that
// pass between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package mbr_pkg;

   localparam int BUFFER_BYTES  = 1024;
   localparam int MAX_READ_BITS = 32;
   localparam int QUEUE_DEPTH   = 2;

   localparam int BYTE_W   = 8;
   localparam int ADDR_W   = $clog2(BUFFER_BYTES);
   localparam int LEN_W    = $clog2(BUFFER_BYTES + 1);
   localparam int POS_W    = LEN_W + 3;
   localparam int COUNT_W  = 14;
   localparam int RD_CNT_W = $clog2(MAX_READ_BITS + 1);
   localparam int VALUE_W  = 32;
   localparam int CAP_BITS = BUFFER_BYTES * 8;

   // bytes touched by the widest read at any bit offset
   localparam int FETCH_BYTES = (MAX_READ_BITS + 7 + 7) / 8;
   localparam int WINDOW_W    = FETCH_BYTES * BYTE_W;
   localparam int ACC_W       = WINDOW_W - BYTE_W;
   localparam int BEAT_W      = $clog2(FETCH_BYTES);
   localparam int SHIFT_W     = $clog2(WINDOW_W + 1);

   typedef enum logic [1:0] {
      REQ_LOAD = 2'd0,
      REQ_READ = 2'd1,
      REQ_SHOW = 2'd2,
      REQ_SKIP = 2'd3
   } req_op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_PAST_END = 2'd1,
      ST_TOO_MANY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_EXTRACT = 2'd1,
      CMD_REPORT  = 2'd2
   } cmd_op_type;

   typedef enum logic {
      BK_IDLE  = 1'b0,
      BK_FETCH = 1'b1
   } back_state_type;

   typedef struct packed {
      cmd_op_type          op;
      status_type          status;
      logic [POS_W-1:0]    start;
      logic [RD_CNT_W-1:0] count;
      logic [ADDR_W-1:0]   addr;
      logic [BYTE_W-1:0]   data;
   } cmd_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      status_type         status;
   } rsp_item_type;

endpackage

FILE: sv/msb_first_bit_reader_unit.sv
// ----------------------------------------------------------------------------
// msb_first_bit_reader_unit: MSB-first bit reader over a loadable byte buffer
// Requests enter through push/full, results leave through empty/pop, one
// result per request in request order. csr_write_en/csr_write_data set the
// buffer length in bytes and restart the bit position at zero; write it only
// while no request is outstanding.
// Load, skip and rejected reads are done in the back end's idle state; a read or
// show fetches five buffer bytes, one per cycle through the single RAM read port.
// The front end updates the bit position as it accepts a request, so requests
// queue up in a two-entry command queue while the back end works.
// Reset clears the position, the length and both queues; buffer contents stay
// undefined until loaded. When the receiver stops popping, the two-entry
// result queue fills, the back end holds, the command queue fills and full
// rises; nothing is dropped.
// ----------------------------------------------------------------------------
module msb_first_bit_reader_unit #(
   parameter int QUEUE_DEPTH = mbr_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [mbr_pkg::LEN_W-1:0]    csr_write_data,
   input  logic                         push,
   output logic                         full,
   input  logic [1:0]                   req_type,
   input  logic [mbr_pkg::COUNT_W-1:0]  req_bit_count,
   input  logic [mbr_pkg::ADDR_W-1:0]   req_load_addr,
   input  logic [mbr_pkg::BYTE_W-1:0]   req_load_byte,
   output logic                         empty,
   input  logic                         pop,
   output logic [mbr_pkg::VALUE_W-1:0]  rsp_value,
   output logic [1:0]                   rsp_status
);

   mbr_pkg::cmd_type              cmd_new, cmd_head;
   logic                          cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic [mbr_pkg::LEN_W-1:0]     buffer_len;
   logic                          ram_wr_en;
   logic [mbr_pkg::ADDR_W-1:0]    ram_wr_addr, ram_rd_addr;
   logic [mbr_pkg::BYTE_W-1:0]    ram_wr_data, ram_rd_data;
   logic                          rsp_push, rsp_full;
   mbr_pkg::rsp_item_type         rsp_new, rsp_head;

   mbr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_bit_count  (req_bit_count),
      .req_load_addr  (req_load_addr),
      .req_load_byte  (req_load_byte),
      .cmd_full       (cmd_full),
      .cmd_push       (cmd_push),
      .cmd            (cmd_new),
      .buffer_len     (buffer_len)
   );

   mbr_fifo #(
      .WIDTH ($bits(mbr_pkg::cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_new),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_head),
      .empty     (cmd_empty)
   );

   mbr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_empty   (cmd_empty),
      .cmd         (cmd_head),
      .cmd_pop     (cmd_pop),
      .buffer_len  (buffer_len),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_full    (rsp_full),
      .rsp_push    (rsp_push),
      .rsp_item    (rsp_new)
   );

   mbr_ram #(
      .WIDTH (mbr_pkg::BYTE_W),
      .DEPTH (mbr_pkg::BUFFER_BYTES)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mbr_fifo #(
      .WIDTH ($bits(mbr_pkg::rsp_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_new),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_head),
      .empty     (empty)
   );

   assign rsp_value  = rsp_head.value;
   assign rsp_status = rsp_head.status;

endmodule

FILE: sv/mbr_ram.sv
// ----------------------------------------------------------------------------
// mbr_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/mbr_fifo.sv
// ----------------------------------------------------------------------------
// mbr_fifo: small register queue
// Power-of-two depth, push/full on the write side, pop/empty on the read side.
// ----------------------------------------------------------------------------
module mbr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W:0]   rd_ptr_ff, rd_ptr_in;
   logic             do_push, do_pop;

   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[PTR_W] != rd_ptr_ff[PTR_W]) &&
                  (wr_ptr_ff[PTR_W-1:0] == rd_ptr_ff[PTR_W-1:0]);

   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   assign pop_data = slot_ff[rd_ptr_ff[PTR_W-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff[PTR_W-1:0]] <= push_data;
      end
   end

endmodule

FILE: sv/mbr_front.sv
// ----------------------------------------------------------------------------
// mbr_front: request front end
// Holds buffer length and bit position, classifies each request, computes
// its status and start position, and queues a command for the back end.
// ----------------------------------------------------------------------------
module mbr_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [mbr_pkg::LEN_W-1:0]    csr_write_data,
   input  logic                         push,
   output logic                         full,
   input  logic [1:0]                   req_type,
   input  logic [mbr_pkg::COUNT_W-1:0]  req_bit_count,
   input  logic [mbr_pkg::ADDR_W-1:0]   req_load_addr,
   input  logic [mbr_pkg::BYTE_W-1:0]   req_load_byte,
   input  logic                         cmd_full,
   output logic                         cmd_push,
   output mbr_pkg::cmd_type             cmd,
   output logic [mbr_pkg::LEN_W-1:0]    buffer_len
);

   localparam int SUM_W = mbr_pkg::POS_W + 1;

   logic [mbr_pkg::LEN_W-1:0] len_ff, len_in;
   logic [mbr_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [mbr_pkg::POS_W-1:0] valid_bits;
   logic [SUM_W-1:0]          sum;
   logic [mbr_pkg::POS_W-1:0] pos_sat;
   logic                      past_end;
   logic                      too_many;
   logic                      accept;
   logic                      advance;
   mbr_pkg::req_op_type       op;

   assign op         = mbr_pkg::req_op_type'(req_type);
   assign full       = cmd_full;
   assign accept     = push && !cmd_full;
   assign cmd_push   = accept;
   assign buffer_len = len_ff;

   assign valid_bits = {len_ff, 3'b000};
   assign sum        = {1'b0, pos_ff} + SUM_W'(req_bit_count);
   assign past_end   = sum > {1'b0, valid_bits};
   assign pos_sat    = (sum > SUM_W'(mbr_pkg::CAP_BITS)) ?
                       mbr_pkg::POS_W'(mbr_pkg::CAP_BITS) : sum[mbr_pkg::POS_W-1:0];
   assign too_many   = req_bit_count > mbr_pkg::COUNT_W'(mbr_pkg::MAX_READ_BITS);

   always_comb begin
      cmd.op     = mbr_pkg::CMD_REPORT;
      cmd.status = mbr_pkg::ST_OK;
      cmd.start  = pos_ff;
      cmd.count  = req_bit_count[mbr_pkg::RD_CNT_W-1:0];
      cmd.addr   = req_load_addr;
      cmd.data   = req_load_byte;
      advance    = 1'b0;
      unique case (op)
         mbr_pkg::REQ_LOAD: begin
            cmd.op = mbr_pkg::CMD_LOAD;
         end
         mbr_pkg::REQ_SKIP: begin
            cmd.status = past_end ? mbr_pkg::ST_PAST_END : mbr_pkg::ST_OK;
            advance    = 1'b1;
         end
         mbr_pkg::REQ_READ, mbr_pkg::REQ_SHOW: begin
            if (too_many) begin
               cmd.status = mbr_pkg::ST_TOO_MANY;
            end else begin
               cmd.op     = mbr_pkg::CMD_EXTRACT;
               cmd.status = past_end ? mbr_pkg::ST_PAST_END : mbr_pkg::ST_OK;
               advance    = (op == mbr_pkg::REQ_READ);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      len_in = len_ff;
      pos_in = pos_ff;
      if (csr_write_en) begin
         // clamp to capacity and restart at bit zero
         len_in = (csr_write_data > mbr_pkg::LEN_W'(mbr_pkg::BUFFER_BYTES)) ?
                  mbr_pkg::LEN_W'(mbr_pkg::BUFFER_BYTES) : csr_write_data;
         pos_in = '0;
      end else if (accept && advance) begin
         pos_in = pos_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         pos_ff <= '0;
      end else begin
         len_ff <= len_in;
         pos_ff <= pos_in;
      end
   end

endmodule

FILE: sv/mbr_back.sv
// ----------------------------------------------------------------------------
// mbr_back: command back end
// Writes loaded bytes, fetches the byte window of a read or show one byte
// per cycle from the RAM, and aligns the requested bits into the result.
// ----------------------------------------------------------------------------
module mbr_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_empty,
   input  mbr_pkg::cmd_type             cmd,
   output logic                         cmd_pop,
   input  logic [mbr_pkg::LEN_W-1:0]    buffer_len,
   output logic                         ram_wr_en,
   output logic [mbr_pkg::ADDR_W-1:0]   ram_wr_addr,
   output logic [mbr_pkg::BYTE_W-1:0]   ram_wr_data,
   output logic [mbr_pkg::ADDR_W-1:0]   ram_rd_addr,
   input  logic [mbr_pkg::BYTE_W-1:0]   ram_rd_data,
   input  logic                         rsp_full,
   output logic                         rsp_push,
   output mbr_pkg::rsp_item_type        rsp_item
);

   mbr_pkg::back_state_type        state_ff, state_in;
   logic [mbr_pkg::LEN_W-1:0]      base_ff, base_in;
   logic [2:0]                     off_ff, off_in;
   logic [mbr_pkg::RD_CNT_W-1:0]   count_ff, count_in;
   mbr_pkg::status_type            status_ff, status_in;
   logic [mbr_pkg::BEAT_W-1:0]     beat_ff, beat_in;
   logic [mbr_pkg::ACC_W-1:0]      acc_ff, acc_in;

   logic                           can_start;
   logic                           last_beat;
   logic [mbr_pkg::LEN_W-1:0]      fetch_index;
   logic [mbr_pkg::LEN_W-1:0]      next_index;
   logic [mbr_pkg::BYTE_W-1:0]     byte_in;
   logic [mbr_pkg::WINDOW_W-1:0]   window;
   logic [mbr_pkg::SHIFT_W-1:0]    shift_amt;
   logic [mbr_pkg::WINDOW_W-1:0]   shifted;
   logic [mbr_pkg::VALUE_W:0]      mask;
   logic [mbr_pkg::VALUE_W-1:0]    extracted;

   assign can_start   = !cmd_empty && !rsp_full;
   assign last_beat   = (beat_ff == mbr_pkg::BEAT_W'(mbr_pkg::FETCH_BYTES - 1));
   assign fetch_index = base_ff + mbr_pkg::LEN_W'(beat_ff);
   assign next_index  = fetch_index + 1'b1;

   // bytes at or past the buffer length read as zero
   assign byte_in   = (fetch_index < buffer_len) ? ram_rd_data : '0;
   assign window    = {acc_ff, byte_in};
   assign shift_amt = mbr_pkg::SHIFT_W'(mbr_pkg::WINDOW_W) - mbr_pkg::SHIFT_W'(off_ff)
                      - mbr_pkg::SHIFT_W'(count_ff);
   assign shifted   = window >> shift_amt;
   assign mask      = ~({(mbr_pkg::VALUE_W + 1){1'b1}} << count_ff);
   assign extracted = shifted[mbr_pkg::VALUE_W-1:0] & mask[mbr_pkg::VALUE_W-1:0];

   assign ram_wr_addr = cmd.addr;
   assign ram_wr_data = cmd.data;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbr_pkg::BK_IDLE: begin
            if (can_start && cmd.op == mbr_pkg::CMD_EXTRACT) begin
               state_in = mbr_pkg::BK_FETCH;
            end
         end
         mbr_pkg::BK_FETCH: begin
            if (last_beat) begin
               state_in = mbr_pkg::BK_IDLE;
            end
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop         = 1'b0;
      ram_wr_en       = 1'b0;
      ram_rd_addr     = cmd.start[mbr_pkg::ADDR_W+2:3];
      rsp_push        = 1'b0;
      rsp_item.value  = '0;
      rsp_item.status = mbr_pkg::ST_OK;
      unique case (state_ff)
         mbr_pkg::BK_IDLE: begin
            if (can_start) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  mbr_pkg::CMD_LOAD: begin
                     ram_wr_en = 1'b1;
                     rsp_push  = 1'b1;
                  end
                  mbr_pkg::CMD_REPORT: begin
                     rsp_push        = 1'b1;
                     rsp_item.status = cmd.status;
                  end
                  default: begin
                  end
               endcase
            end
         end
         mbr_pkg::BK_FETCH: begin
            ram_rd_addr = next_index[mbr_pkg::ADDR_W-1:0];
            if (last_beat) begin
               rsp_push        = 1'b1;
               rsp_item.value  = extracted;
               rsp_item.status = status_ff;
            end
         end
      endcase
   end

   always_comb begin
      base_in   = base_ff;
      off_in    = off_ff;
      count_in  = count_ff;
      status_in = status_ff;
      beat_in   = beat_ff;
      acc_in    = acc_ff;
      if (state_ff == mbr_pkg::BK_IDLE) begin
         base_in   = cmd.start[mbr_pkg::POS_W-1:3];
         off_in    = cmd.start[2:0];
         count_in  = cmd.count;
         status_in = cmd.status;
         beat_in   = '0;
         acc_in    = '0;
      end else begin
         beat_in = beat_ff + 1'b1;
         acc_in  = window[mbr_pkg::ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbr_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      off_ff    <= off_in;
      count_ff  <= count_in;
      status_ff <= status_in;
      beat_ff   <= beat_in;
      acc_ff    <= acc_in;
   end

endmodule

FILE: tb/tb_msb_first_bit_reader_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_msb_first_bit_reader_unit: self-checking bench for the MSB-first reader
// Drives load, read, show and skip requests through the push/full queue and
// checks every result popped from the empty/pop queue against a bit-level
// model of the buffer and bit position. Covers the empty buffer, directed
// edge cases, a full buffer fill and random request streams at several
// buffer lengths, with bursty sending and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_msb_first_bit_reader_unit;

   localparam int CYCLE_LIMIT = 400000;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_write_en;
   logic [mbr_pkg::LEN_W-1:0]    csr_write_data;
   logic                         push;
   logic                         full;
   logic [1:0]                   req_type;
   logic [mbr_pkg::COUNT_W-1:0]  req_bit_count;
   logic [mbr_pkg::ADDR_W-1:0]   req_load_addr;
   logic [mbr_pkg::BYTE_W-1:0]   req_load_byte;
   logic                         empty;
   logic                         pop = 1'b0;
   logic [mbr_pkg::VALUE_W-1:0]  rsp_value;
   logic [1:0]                   rsp_status;

   // shadow of the block state
   logic [mbr_pkg::BYTE_W-1:0]   shadow_mem [0:mbr_pkg::BUFFER_BYTES-1];
   logic [mbr_pkg::POS_W-1:0]    shadow_pos;
   logic [mbr_pkg::LEN_W-1:0]    shadow_len;

   mbr_pkg::rsp_item_type        expected_rsp[$];

   int unsigned         error_count  = 0;
   int unsigned         rsp_checked  = 0;
   int unsigned         op_count [4] = '{0, 0, 0, 0};
   int unsigned         len_writes   = 0;
   int unsigned         cycle_count  = 0;

   // sender burst control
   int unsigned         burst_left   = 0;
   int unsigned         tx_gap_max   = 0;

   // receiver stall pattern
   int unsigned         rx_mode      = 0;
   int unsigned         rx_mode_left = 0;
   int unsigned         stall_left   = 0;

   msb_first_bit_reader_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_bit_count  (req_bit_count),
      .req_load_addr  (req_load_addr),
      .req_load_byte  (req_load_byte),
      .empty          (empty),
      .pop            (pop),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_rsp.size());
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model
   function automatic void advance_pos(input int unsigned cnt);
      int unsigned np;
      np = shadow_pos + cnt;
      shadow_pos = (np > mbr_pkg::CAP_BITS) ? mbr_pkg::POS_W'(mbr_pkg::CAP_BITS) :
                                             mbr_pkg::POS_W'(np);
   endfunction

   function automatic void predict_bits(input mbr_pkg::req_op_type op,
                                        input int unsigned cnt,
                                        input logic [mbr_pkg::ADDR_W-1:0] addr,
                                        input logic [mbr_pkg::BYTE_W-1:0] data,
                                        output mbr_pkg::rsp_item_type res);
      int unsigned limit_bits;
      int unsigned p;
      logic [mbr_pkg::VALUE_W-1:0] acc;
      res.value  = '0;
      res.status = mbr_pkg::ST_OK;
      limit_bits = shadow_len * 8;
      acc = '0;
      case (op)
         mbr_pkg::REQ_LOAD: begin
            shadow_mem[addr] = data;
         end
         mbr_pkg::REQ_SKIP: begin
            if (shadow_pos + cnt > limit_bits) res.status = mbr_pkg::ST_PAST_END;
            advance_pos(cnt);
         end
         default: begin
            if (cnt > mbr_pkg::MAX_READ_BITS) begin
               res.status = mbr_pkg::ST_TOO_MANY;
            end else begin
               if (shadow_pos + cnt > limit_bits) res.status = mbr_pkg::ST_PAST_END;
               for (int i = 0; i < cnt; i++) begin
                  p = shadow_pos + i;
                  // bits at or past the valid length read as zero
                  acc = {acc[mbr_pkg::VALUE_W-2:0],
                         (p < limit_bits) ? shadow_mem[p >> 3][7 - (p & 7)] : 1'b0};
               end
               res.value = acc;
               if (op == mbr_pkg::REQ_READ) advance_pos(cnt);
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- checker
   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR at cycle %0d: %s", cycle_count, msg);
   endtask

   always @(posedge clock) begin
      mbr_pkg::rsp_item_type want;
      if (!reset && pop && !empty) begin
         rsp_checked++;
         if (expected_rsp.size() == 0) begin
            note_error($sformatf("unexpected result value=%h status=%0d",
                                 rsp_value, rsp_status));
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_value !== want.value)
               note_error($sformatf("result %0d value exp=%h act=%h",
                                    rsp_checked, want.value, rsp_value));
            if (rsp_status !== want.status)
               note_error($sformatf("result %0d status exp=%0d act=%0d",
                                    rsp_checked, want.status, rsp_status));
         end
      end
   end

   // receiver: free-running, half-rate, sporadic long stalls, mostly stalled
   always @(posedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      <= $urandom_range(0, 3);
         rx_mode_left <= $urandom_range(64, 256);
      end else begin
         rx_mode_left <= rx_mode_left - 1;
      end
      if (stall_left != 0) begin
         pop        <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         case (rx_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 1) == 1);
            2: begin
               pop <= 1'b1;
               if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(1, 20);
            end
            default: pop <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------- driving
   task automatic send_req(input mbr_pkg::req_op_type op, input int unsigned cnt,
                           input logic [mbr_pkg::ADDR_W-1:0] addr,
                           input logic [mbr_pkg::BYTE_W-1:0] data);
      mbr_pkg::rsp_item_type res;
      int unsigned gap;
      push          <= 1'b1;
      req_type      <= op;
      req_bit_count <= mbr_pkg::COUNT_W'(cnt);
      req_load_addr <= addr;
      req_load_byte <= data;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_bits(op, cnt & 16'h3FFF, addr, data, res);
      expected_rsp.push_back(res);
      op_count[op]++;
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
         if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_rand_fields(input mbr_pkg::req_op_type op, input int unsigned cnt);
      send_req(op, cnt,
               mbr_pkg::ADDR_W'($urandom_range(0, mbr_pkg::BUFFER_BYTES - 1)),
               mbr_pkg::BYTE_W'($urandom_range(0, 255)));
   endtask

   // drain all results, then write the length register while idle
   task automatic write_buffer_len(input int unsigned len_val);
      push <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= mbr_pkg::LEN_W'(len_val);
      @(posedge clock);
      shadow_len = (len_val > mbr_pkg::BUFFER_BYTES) ?
                   mbr_pkg::LEN_W'(mbr_pkg::BUFFER_BYTES) : mbr_pkg::LEN_W'(len_val);
      shadow_pos = '0;
      len_writes++;
      csr_write_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests
   // length zero straight from reset: accesses of one bit or more run past the end, but the 33-bit read is rejected
   task automatic test_empty_buffer();
      tx_gap_max = 3;
      send_rand_fields(mbr_pkg::REQ_READ, 0);
      send_rand_fields(mbr_pkg::REQ_READ, 32);
      send_rand_fields(mbr_pkg::REQ_SHOW, 1);
      send_rand_fields(mbr_pkg::REQ_SKIP, 8192);
      send_rand_fields(mbr_pkg::REQ_READ, 33);
      send_rand_fields(mbr_pkg::REQ_SKIP, 16383);
   endtask

   task automatic test_directed_reads();
      logic [mbr_pkg::BYTE_W-1:0] pattern [8] = '{8'h80, 8'hFF, 8'h00, 8'hA5,
                                                  8'h5A, 8'h01, 8'hFE, 8'hC3};
      tx_gap_max = 2;
      for (int i = 0; i < 8; i++)
         send_req(mbr_pkg::REQ_LOAD, $urandom_range(0, 16383), mbr_pkg::ADDR_W'(i),
                  pattern[i]);
      send_req(mbr_pkg::REQ_LOAD, 16383, mbr_pkg::ADDR_W'(mbr_pkg::BUFFER_BYTES - 1),
               8'hFF);
      write_buffer_len(8);
      send_rand_fields(mbr_pkg::REQ_READ, 1);
      send_rand_fields(mbr_pkg::REQ_READ, 7);
      send_rand_fields(mbr_pkg::REQ_SHOW, 32);
      send_rand_fields(mbr_pkg::REQ_READ, 32);
      send_rand_fields(mbr_pkg::REQ_READ, 0);
      send_rand_fields(mbr_pkg::REQ_SHOW, 33);
      send_rand_fields(mbr_pkg::REQ_READ, 16383);
      send_rand_fields(mbr_pkg::REQ_SKIP, 3);
      // crosses the end of the valid bytes
      send_rand_fields(mbr_pkg::REQ_READ, 32);
      send_rand_fields(mbr_pkg::REQ_SKIP, 8192);
      send_rand_fields(mbr_pkg::REQ_READ, 5);
   endtask

   // load every byte so any later length reads written data only
   task automatic test_fill_buffer();
      for (int a = 0; a < mbr_pkg::BUFFER_BYTES; a++) begin
         if (a % 128 == 0) tx_gap_max = $urandom_range(0, 6);
         send_req(mbr_pkg::REQ_LOAD, $urandom_range(0, 16383), mbr_pkg::ADDR_W'(a),
                  mbr_pkg::BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_random_stream(input int unsigned len_val, input int unsigned n_items);
      int unsigned sel;
      write_buffer_len(len_val);
      tx_gap_max = $urandom_range(0, 8);
      for (int n = 0; n < n_items; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            send_rand_fields(mbr_pkg::REQ_READ, $urandom_range(0, mbr_pkg::MAX_READ_BITS));
         end else if (sel < 70) begin
            send_rand_fields(mbr_pkg::REQ_SHOW, $urandom_range(0, mbr_pkg::MAX_READ_BITS));
         end else if (sel < 82) begin
            send_rand_fields(mbr_pkg::REQ_SKIP, ($urandom_range(0, 9) == 0) ?
                             $urandom_range(0, 16383) : $urandom_range(0, 48));
         end else if (sel < 88) begin
            send_rand_fields($urandom_range(0, 1) ? mbr_pkg::REQ_READ : mbr_pkg::REQ_SHOW,
                             $urandom_range(mbr_pkg::MAX_READ_BITS + 1, 16383));
         end else begin
            send_rand_fields(mbr_pkg::REQ_LOAD, $urandom_range(0, 16383));
         end
      end
   endtask

   task automatic finish_run();
      push <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Ran %0d loads, %0d reads, %0d shows, %0d skips over %0d length settings",
               op_count[mbr_pkg::REQ_LOAD], op_count[mbr_pkg::REQ_READ],
               op_count[mbr_pkg::REQ_SHOW], op_count[mbr_pkg::REQ_SKIP], len_writes);
      $display("Checked %0d results, %0d mismatches", rsp_checked, error_count);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   endtask

   initial begin
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      push           = 1'b0;
      req_type       = mbr_pkg::REQ_LOAD;
      req_bit_count  = '0;
      req_load_addr  = '0;
      req_load_byte  = '0;
      shadow_pos     = '0;
      shadow_len     = '0;
      for (int i = 0; i < mbr_pkg::BUFFER_BYTES; i++) shadow_mem[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_buffer();
      test_directed_reads();
      test_fill_buffer();
      // above capacity clamps to the full buffer
      test_random_stream(2047, 200);
      test_random_stream(0, 30);
      test_random_stream(1, 30);
      test_random_stream(mbr_pkg::BUFFER_BYTES, 120);
      test_random_stream(mbr_pkg::BUFFER_BYTES + 1, 40);
      for (int k = 0; k < 4; k++)
         test_random_stream($urandom_range(1, mbr_pkg::BUFFER_BYTES - 1), 50);
      finish_run();
   end

endmodule
